/* sv/point_rotate_about_axis_defines.svh */
// Assertion macros for the point rotation block.
// Included by the top level; no other dependencies.
`ifndef POINT_ROTATE_ABOUT_AXIS_DEFINES_SVH
`define POINT_ROTATE_ABOUT_AXIS_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PRA_ASSERT_RESET(lbl, clk, rst, cons, msg) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);
`define PRA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define PRA_ASSERT_RESET(lbl, clk, rst, cons, msg)
`define PRA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* sv/pra_pkg.sv */
// Shared types, constants and functions of the point rotation block.
// No dependencies; used by every module of the block.
package pra_pkg;

  localparam int CoordW = 32;
  localparam int AngleW = 26;
  localparam int ZW = 33;
  localparam int SumW = 38;

  localparam logic [26:0] Recip45 = 27'd95443717;
  localparam logic [5:0] Div45 = 6'd45;
  localparam logic [18:0] PhaseBias = 19'd22;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_ROT_X = 2'd0,
    CMD_ROT_Y = 2'd1,
    CMD_ROT_Z = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } item_t;

  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [SumW-1:0] v);
    logic [31:0] r;
    if ((&v[SumW-1:31]) || !(|v[SumW-1:31])) begin
      r = v[31:0];
    end else if (v[SumW-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

/* sv/pra_phase.sv */
// Angle front end: degrees to a binary phase and the half-turn fold.
// Depends on pra_pkg.
module pra_phase (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pra_pkg::AngleW-1:0] angle_deg,
  input  pra_pkg::item_t                    in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pra_pkg::ZW-1:0]     out_z,
  output logic                              out_flip,
  output pra_pkg::item_t                    out_item
);

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5, r6;

  logic [25:0] mag1, mag2;
  logic        neg1, neg2, neg3, neg4;
  logic [19:0] quo2, quo3, quo4;
  logic [5:0]  rem3;
  logic [18:0] vnum4;
  logic [12:0] tq4;
  logic [31:0] phase5;
  pra_pkg::item_t item1, item2, item3, item4, item5;

  logic [25:0] mag_in;
  logic [52:0] prod_a;
  logic [25:0] rem_a;
  logic [18:0] vnum_in;
  logic [45:0] prod_b;
  logic [18:0] rem_b;
  logic [12:0] tq_fix;
  logic [31:0] q32;
  logic [31:0] turned;
  logic        flip_in;

  assign r6 = !out_valid || out_ready;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  assign mag_in = angle_deg[25] ? (~unsigned'(angle_deg) + 26'd1) : unsigned'(angle_deg);
  assign prod_a = 53'(mag1) * 53'(pra_pkg::Recip45);
  assign rem_a = mag2 - (26'(quo2) * 26'(pra_pkg::Div45));
  assign vnum_in = {rem3, 13'd0} + pra_pkg::PhaseBias;
  assign prod_b = 46'(vnum_in) * 46'(pra_pkg::Recip45);
  assign rem_b = vnum4 - (19'(tq4) * 19'(pra_pkg::Div45));
  assign tq_fix = (rem_b >= 19'(pra_pkg::Div45)) ? (tq4 + 13'd1) : tq4;
  assign q32 = {quo4[18:0], 13'd0} + 32'(tq_fix);
  assign turned = phase5 + pra_pkg::QuarterTurn;
  assign flip_in = turned[31];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      mag1 <= mag_in;
      neg1 <= angle_deg[25];
      item1 <= in_item;
    end
    if (r2 && v1) begin
      quo2 <= prod_a[51:32];
      mag2 <= mag1;
      neg2 <= neg1;
      item2 <= item1;
    end
    if (r3 && v2) begin
      if (rem_a[6:0] >= 7'(pra_pkg::Div45)) begin
        quo3 <= quo2 + 20'd1;
        rem3 <= 6'(rem_a[6:0] - 7'(pra_pkg::Div45));
      end else begin
        quo3 <= quo2;
        rem3 <= rem_a[5:0];
      end
      neg3 <= neg2;
      item3 <= item2;
    end
    if (r4 && v3) begin
      vnum4 <= vnum_in;
      tq4 <= prod_b[44:32];
      quo4 <= quo3;
      neg4 <= neg3;
      item4 <= item3;
    end
    if (r5 && v4) begin
      phase5 <= neg4 ? (~q32 + 32'd1) : q32;
      item5 <= item4;
    end
    if (r6 && v5) begin
      out_flip <= flip_in;
      out_z <= signed'(pra_pkg::ZW'(signed'(flip_in ? (phase5 ^ pra_pkg::HalfTurn) : phase5)));
      out_item <= item5;
    end
  end

endmodule

/* sv/pra_cordic_cell.sv */
// One CORDIC rotation step with its own pipeline register.
// Depends on pra_pkg for the arctangent table and the item type.
module pra_cordic_cell #(
  parameter int ITER = 0,
  parameter int XY_W = 19
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [XY_W-1:0]        in_x,
  input  logic signed [XY_W-1:0]        in_y,
  input  logic signed [pra_pkg::ZW-1:0] in_z,
  input  logic                          in_flip,
  input  pra_pkg::item_t                in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [XY_W-1:0]        out_x,
  output logic signed [XY_W-1:0]        out_y,
  output logic signed [pra_pkg::ZW-1:0] out_z,
  output logic                          out_flip,
  output pra_pkg::item_t                out_item
);

  localparam logic signed [pra_pkg::ZW-1:0] Atan = {1'b0, pra_pkg::atan_turn(ITER)};

  logic signed [XY_W-1:0] dx, dy;

  assign in_ready = !out_valid || out_ready;
  assign dx = in_y >>> ITER;
  assign dy = in_x >>> ITER;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      if (!in_z[pra_pkg::ZW-1]) begin
        out_x <= in_x - dx;
        out_y <= in_y + dy;
        out_z <= in_z - Atan;
      end else begin
        out_x <= in_x + dx;
        out_y <= in_y - dy;
        out_z <= in_z + Atan;
      end
      out_flip <= in_flip;
      out_item <= in_item;
    end
  end

endmodule

/* sv/pra_rotate.sv */
// Pair rotation about the pivot: offset, products, rounding, saturation.
// Depends on pra_pkg; holds the output register of the block.
module pra_rotate #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [FRAC_BITS+2:0]        in_cos,
  input  logic signed [FRAC_BITS+2:0]        in_sin,
  input  logic                               in_flip,
  input  pra_pkg::item_t                     in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pra_pkg::CoordW-1:0]  rot_x,
  output logic signed [pra_pkg::CoordW-1:0]  rot_y,
  output logic signed [pra_pkg::CoordW-1:0]  rot_z
);

  localparam int XyW = FRAC_BITS + 3;
  localparam int ProdW = pra_pkg::ZW + XyW;
  localparam int RndW = ProdW + 1 - FRAC_BITS;
  localparam logic signed [ProdW:0] Half = (ProdW + 1)'(1) << (FRAC_BITS - 1);

  logic v1, v2, v3;
  logic r1, r2, r3, r4;

  logic signed [XyW-1:0] c1, s1;
  logic signed [pra_pkg::ZW-1:0] da1, db1;
  logic signed [31:0] oa1, ob1, oa2, ob2, oa3, ob3;
  logic signed [ProdW-1:0] pac2, pbs2, pas2, pbc2;
  logic signed [RndW-1:0] rnd_a3, rnd_b3;
  pra_pkg::item_t item1, item2, item3;

  logic signed [31:0] a_sel, b_sel, oa_sel, ob_sel;
  logic signed [ProdW:0] sum_a, sum_b;
  logic signed [pra_pkg::SumW-1:0] fin_a, fin_b;
  logic signed [31:0] sat_a, sat_b;
  logic signed [31:0] nx, ny, nz;

  assign r4 = !out_valid || out_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  always_comb begin
    a_sel = in_item.point_x;
    b_sel = in_item.point_y;
    oa_sel = in_item.origin_x;
    ob_sel = in_item.origin_y;
    case (in_item.command)
      pra_pkg::CMD_ROT_X: begin
        a_sel = in_item.point_y;
        b_sel = in_item.point_z;
        oa_sel = in_item.origin_y;
        ob_sel = in_item.origin_z;
      end
      pra_pkg::CMD_ROT_Y: begin
        b_sel = in_item.point_z;
        ob_sel = in_item.origin_z;
      end
      default: begin
      end
    endcase
  end

  assign sum_a = (ProdW + 1)'(pac2) - (ProdW + 1)'(pbs2) + Half;
  assign sum_b = (ProdW + 1)'(pas2) + (ProdW + 1)'(pbc2) + Half;
  assign fin_a = pra_pkg::SumW'(rnd_a3) + pra_pkg::SumW'(oa3);
  assign fin_b = pra_pkg::SumW'(rnd_b3) + pra_pkg::SumW'(ob3);
  assign sat_a = pra_pkg::sat32(fin_a);
  assign sat_b = pra_pkg::sat32(fin_b);

  always_comb begin
    nx = item3.point_x;
    ny = item3.point_y;
    nz = item3.point_z;
    case (item3.command)
      pra_pkg::CMD_ROT_X: begin
        ny = sat_a;
        nz = sat_b;
      end
      pra_pkg::CMD_ROT_Y: begin
        nx = sat_a;
        nz = sat_b;
      end
      pra_pkg::CMD_ROT_Z: begin
        nx = sat_a;
        ny = sat_b;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      c1 <= in_flip ? -in_cos : in_cos;
      s1 <= in_flip ? -in_sin : in_sin;
      da1 <= pra_pkg::ZW'(a_sel) - pra_pkg::ZW'(oa_sel);
      db1 <= pra_pkg::ZW'(b_sel) - pra_pkg::ZW'(ob_sel);
      oa1 <= oa_sel;
      ob1 <= ob_sel;
      item1 <= in_item;
    end
    if (r2 && v1) begin
      pac2 <= ProdW'(da1) * ProdW'(c1);
      pbs2 <= ProdW'(db1) * ProdW'(s1);
      pas2 <= ProdW'(da1) * ProdW'(s1);
      pbc2 <= ProdW'(db1) * ProdW'(c1);
      oa2 <= oa1;
      ob2 <= ob1;
      item2 <= item1;
    end
    if (r3 && v2) begin
      rnd_a3 <= sum_a[ProdW:FRAC_BITS];
      rnd_b3 <= sum_b[ProdW:FRAC_BITS];
      oa3 <= oa2;
      ob3 <= ob2;
      item3 <= item2;
    end
    if (r4 && v3) begin
      rot_x <= nx;
      rot_y <= ny;
      rot_z <= nz;
    end
  end

endmodule

/* sv/point_rotate_about_axis.sv */
// Path: the phase stages, one CORDIC cell per iteration, then the rotation stages.
// Throughput: one beat per cycle while out_stall is low; every stage is fully pipelined.
// A stalled output only holds the stages that are full; empty stages keep filling.
// Reset clears every valid bit; payload registers are not reset.
// Depends on pra_pkg, pra_phase, pra_cordic_cell, pra_rotate and the defines header.
`include "point_rotate_about_axis_defines.svh"
module point_rotate_about_axis #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        command,
  input  logic signed [pra_pkg::CoordW-1:0] origin_x,
  input  logic signed [pra_pkg::CoordW-1:0] origin_y,
  input  logic signed [pra_pkg::CoordW-1:0] origin_z,
  input  logic signed [pra_pkg::CoordW-1:0] point_x,
  input  logic signed [pra_pkg::CoordW-1:0] point_y,
  input  logic signed [pra_pkg::CoordW-1:0] point_z,
  input  logic signed [pra_pkg::AngleW-1:0] angle_deg,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pra_pkg::CoordW-1:0] rot_x,
  output logic signed [pra_pkg::CoordW-1:0] rot_y,
  output logic signed [pra_pkg::CoordW-1:0] rot_z
);

  localparam int N = CORDIC_ITERATIONS;
  localparam int XyW = FRAC_BITS + 3;
  localparam logic [63:0] GainQ32 = 64'h9B74EDA8;
  localparam logic [63:0] GainWide = (GainQ32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic signed [XyW-1:0] GainInit = XyW'(GainWide);

  pra_pkg::item_t in_item;
  logic phase_ready;
  logic rot_ready;

  logic                          stage_valid [0:N];
  logic                          stage_ready [0:N];
  logic signed [XyW-1:0]         stage_x     [0:N];
  logic signed [XyW-1:0]         stage_y     [0:N];
  logic signed [pra_pkg::ZW-1:0] stage_z     [0:N];
  logic                          stage_flip  [0:N];
  pra_pkg::item_t                stage_item  [0:N];

  assign in_item = '{
    command:  pra_pkg::cmd_t'(command),
    origin_x: origin_x,
    origin_y: origin_y,
    origin_z: origin_z,
    point_x:  point_x,
    point_y:  point_y,
    point_z:  point_z
  };

  assign in_stall = !phase_ready;
  assign stage_x[0] = GainInit;
  assign stage_y[0] = '0;

  pra_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (phase_ready),
    .angle_deg (angle_deg),
    .in_item   (in_item),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_z     (stage_z[0]),
    .out_flip  (stage_flip[0]),
    .out_item  (stage_item[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    pra_cordic_cell #(
      .ITER (i),
      .XY_W (XyW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_x      (stage_x[i]),
      .in_y      (stage_y[i]),
      .in_z      (stage_z[i]),
      .in_flip   (stage_flip[i]),
      .in_item   (stage_item[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_x     (stage_x[i+1]),
      .out_y     (stage_y[i+1]),
      .out_z     (stage_z[i+1]),
      .out_flip  (stage_flip[i+1]),
      .out_item  (stage_item[i+1])
    );
  end

  assign stage_ready[N] = rot_ready;

  pra_rotate #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[N]),
    .in_ready  (rot_ready),
    .in_cos    (stage_x[N]),
    .in_sin    (stage_y[N]),
    .in_flip   (stage_flip[N]),
    .in_item   (stage_item[N]),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z)
  );

  `PRA_ASSERT_RESET(a_reset_empty, clk, rst, !out_valid && !stage_valid[0], "pipeline not empty after reset")
  `PRA_ASSERT_IMP(a_no_stall_through, clk, rst, !out_stall, !in_stall, "input stalled while output drains")
  `PRA_ASSERT_IMP(a_cell_handoff, clk, rst, $rose(stage_valid[N]), $past(stage_valid[N-1] && stage_ready[N-1]), "last cell filled without a handoff")

endmodule
